[hdl/atg_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// atg_pkg: shared types and constants of the tile geometry unit
// Coordinate widths, pipeline word layouts, register indexes and helpers.
// ----------------------------------------------------------------------------
package atg_pkg;

  localparam int COORD_W            = 24;
  localparam int RAW_W              = 14;
  localparam int SIZE_W             = 11;
  localparam int IDX_W              = 4;
  localparam int IDXC_W             = 6;
  localparam int PROD_W             = 48;
  localparam int MAG_W              = 48;
  localparam int SQ_IN_W            = 64;
  localparam int ROOT_W             = 32;
  localparam int QUO_W              = 25;
  localparam int NUM_W              = QUO_W + ROOT_W - 1;
  localparam int WIDE_W             = 33;
  localparam int CFG_IDX_W          = 1;
  localparam int FRAC_BITS_DEF      = 8;
  localparam int MAX_TILE_INDEX_DEF = 15;

  localparam logic [RAW_W-1:0]  RAW_MAX    = '1;
  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(128);

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_TILE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TILE_HEIGHT = 1'b1;

  typedef logic signed [COORD_W-1:0] coord_t;

  // Per-tile word that travels beside the arithmetic pipelines.
  typedef struct packed {
    logic [RAW_W-1:0] raw_col;
    logic [RAW_W-1:0] raw_row;
    coord_t           fx;
    coord_t           fy;
    coord_t           sx;
    coord_t           sy;
    coord_t           cx;
    coord_t           cy;
    logic [MAG_W-1:0] dot_mag;
    logic [MAG_W-1:0] crs_mag;
    logic             dot_neg;
    logic             degen;
    logic             sat;
  } side_t;

  // Finished result word.
  typedef struct packed {
    logic [RAW_W-1:0] raw_col;
    logic [RAW_W-1:0] raw_row;
    coord_t           fx;
    coord_t           fy;
    coord_t           sx;
    coord_t           sy;
    coord_t           cx;
    coord_t           cy;
    coord_t           vx;
    coord_t           vy;
    logic             degen;
    logic             sat;
  } res_t;

  // Clip a wide signed value to the coordinate range; the top bit flags a clip.
  function automatic logic [COORD_W:0] clip_coord(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    logic [COORD_W:0]         r;
    hi = WIDE_W'(signed'({1'b0, {(COORD_W-1){1'b1}}}));
    lo = -hi - WIDE_W'(1);
    if (v > hi) begin
      r = {1'b1, 1'b0, {(COORD_W-1){1'b1}}};
    end else if (v < lo) begin
      r = {1'b1, 1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      r = {1'b0, v[COORD_W-1:0]};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[hdl/atg_in_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// atg_in_if: tile description channel
// Valid/ready channel that carries one tile description per word.
// ----------------------------------------------------------------------------
interface atg_in_if;
  import atg_pkg::*;

  logic               valid;
  logic               ready;
  logic [IDX_W-1:0]   tile_col;
  logic [IDX_W-1:0]   tile_row;
  coord_t             first_x;
  coord_t             first_y;
  coord_t             next_fast_x;
  coord_t             next_fast_y;
  coord_t             next_slow_x;
  coord_t             next_slow_y;

  modport source (output valid, tile_col, tile_row, first_x, first_y, next_fast_x,
                  next_fast_y, next_slow_x, next_slow_y, input ready);
  modport sink (input valid, tile_col, tile_row, first_x, first_y, next_fast_x,
                next_fast_y, next_slow_x, next_slow_y, output ready);
endinterface

`default_nettype wire

[hdl/atg_out_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// atg_out_if: tile geometry result channel
// Valid/ready channel that carries one geometry result per word.
// ----------------------------------------------------------------------------
interface atg_out_if;
  import atg_pkg::*;

  logic             valid;
  logic             ready;
  logic [RAW_W-1:0] raw_first_col;
  logic [RAW_W-1:0] raw_first_row;
  coord_t           fast_step_x;
  coord_t           fast_step_y;
  coord_t           slow_step_x;
  coord_t           slow_step_y;
  coord_t           corner_x;
  coord_t           corner_y;
  coord_t           virtual_zero_x;
  coord_t           virtual_zero_y;
  logic             degenerate;
  logic             saturated;

  modport source (output valid, raw_first_col, raw_first_row, fast_step_x, fast_step_y,
                  slow_step_x, slow_step_y, corner_x, corner_y, virtual_zero_x,
                  virtual_zero_y, degenerate, saturated, input ready);
  modport sink (input valid, raw_first_col, raw_first_row, fast_step_x, fast_step_y,
                slow_step_x, slow_step_y, corner_x, corner_y, virtual_zero_x,
                virtual_zero_y, degenerate, saturated, output ready);
endinterface

`default_nettype wire

[hdl/atg_isqrt.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// atg_isqrt: pipelined integer square root
// One result bit per stage, restoring method; floor of the root.
// ----------------------------------------------------------------------------
module atg_isqrt (
  input  wire logic                         clk,
  input  wire logic                         en,
  input  wire logic [atg_pkg::SQ_IN_W-1:0]  n_i,
  output logic      [atg_pkg::ROOT_W-1:0]   root_o
);
  import atg_pkg::*;

  logic [ROOT_W+1:0]  rem_r [ROOT_W];
  logic [ROOT_W-1:0]  res_r [ROOT_W];
  logic [SQ_IN_W-1:0] nsh_r [ROOT_W];

  for (genvar i = 0; i < ROOT_W; i++) begin : g_stg
    logic [ROOT_W+1:0]  rem_p;
    logic [ROOT_W-1:0]  res_p;
    logic [SQ_IN_W-1:0] n_p;
    logic [ROOT_W+1:0]  rem_in;
    logic [ROOT_W+1:0]  trial;
    logic               ge;

    if (i == 0) begin : g_first
      assign rem_p = '0;
      assign res_p = '0;
      assign n_p   = n_i;
    end else begin : g_next
      assign rem_p = rem_r[i-1];
      assign res_p = res_r[i-1];
      assign n_p   = nsh_r[i-1];
    end

    // Bring down the next two radicand bits and try the next root bit.
    assign rem_in = {rem_p[ROOT_W-1:0], n_p[SQ_IN_W-1:SQ_IN_W-2]};
    assign trial  = {res_p, 2'b01};
    assign ge     = (rem_in >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i] <= ge ? (rem_in - trial) : rem_in;
        res_r[i] <= {res_p[ROOT_W-2:0], ge};
        nsh_r[i] <= {n_p[SQ_IN_W-3:0], 2'b00};
      end
    end
  end

  assign root_o = res_r[ROOT_W-1];

endmodule

`default_nettype wire

[hdl/atg_div.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// atg_div: pipelined unsigned divider
// One quotient bit per stage, restoring method; the quotient must fit.
// ----------------------------------------------------------------------------
module atg_div (
  input  wire logic                        clk,
  input  wire logic                        en,
  input  wire logic [atg_pkg::NUM_W-1:0]   num_i,
  input  wire logic [atg_pkg::ROOT_W-1:0]  den_i,
  output logic      [atg_pkg::QUO_W-1:0]   quo_o
);
  import atg_pkg::*;

  logic [ROOT_W:0]   rem_r [QUO_W];
  logic [QUO_W-1:0]  low_r [QUO_W];
  logic [QUO_W-1:0]  quo_r [QUO_W];
  logic [ROOT_W-1:0] den_r [QUO_W];

  for (genvar i = 0; i < QUO_W; i++) begin : g_stg
    logic [ROOT_W:0]   rem_p;
    logic [QUO_W-1:0]  low_p;
    logic [QUO_W-1:0]  quo_p;
    logic [ROOT_W-1:0] den_p;
    logic [ROOT_W:0]   rem_in;
    logic              ge;

    if (i == 0) begin : g_first
      assign rem_p = (ROOT_W+1)'(num_i[NUM_W-1:QUO_W]);
      assign low_p = num_i[QUO_W-1:0];
      assign quo_p = '0;
      assign den_p = den_i;
    end else begin : g_next
      assign rem_p = rem_r[i-1];
      assign low_p = low_r[i-1];
      assign quo_p = quo_r[i-1];
      assign den_p = den_r[i-1];
    end

    // Shift in the next dividend bit and subtract when the divisor fits.
    assign rem_in = {rem_p[ROOT_W-1:0], low_p[QUO_W-1]};
    assign ge     = (rem_in >= {1'b0, den_p});

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i] <= ge ? (rem_in - {1'b0, den_p}) : rem_in;
        low_r[i] <= {low_p[QUO_W-2:0], 1'b0};
        quo_r[i] <= {quo_p[QUO_W-2:0], ge};
        den_r[i] <= den_p;
      end
    end
  end

  assign quo_o = quo_r[QUO_W-1];

endmodule

`default_nettype wire

[hdl/asic_tile_geometry_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// asic_tile_geometry_unit: detector tile geometry
// Step vectors, corner and virtual zero position of one tile per word.
// ----------------------------------------------------------------------------
// The unit takes one tile description every clock cycle while the skid register
// is empty; while a result waits there, the input is held. A 32-stage square root
// gives the fast-scan step length and the two 25-stage dividers follow it;
// three front stages form the step vectors, the corner and the products, one
// stage rounds the dividends and a last stage adds and clips. A two-entry
// output (result register plus skid register) lets a new tile enter while a
// finished result waits to be taken. Tile sizes are to be written through the
// configuration port only while the unit is idle; the block itself does not
// enforce this.
module asic_tile_geometry_unit #(
  parameter int FRAC_BITS      = atg_pkg::FRAC_BITS_DEF,
  parameter int MAX_TILE_INDEX = atg_pkg::MAX_TILE_INDEX_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  atg_in_if.sink                              in_ch,
  atg_out_if.source                           out_ch,
  input  wire logic                           cfg_we,
  input  wire logic [atg_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [atg_pkg::SIZE_W-1:0]     cfg_wdata
);
  import atg_pkg::*;

  localparam int SQ_FIRST  = 3;
  localparam int SQ_LAST   = SQ_FIRST + ROOT_W - 1;
  localparam int PREP      = SQ_LAST + 1;
  localparam int DIV_FIRST = PREP + 1;
  localparam int DIV_LAST  = DIV_FIRST + QUO_W - 1;
  localparam int FIN       = DIV_LAST + 1;
  localparam int NSTG      = FIN + 1;

  logic [SIZE_W-1:0] tile_width_r;
  logic [SIZE_W-1:0] tile_height_r;
  logic [NSTG-1:0]   vld_r;
  logic              en;
  side_t             side_r [DIV_LAST+1];
  side_t             side0;
  logic signed [PROD_W-1:0] fxx_r, fyy_r, fxcx_r, fycy_r, fxcy_r, fycx_r;
  logic [SQ_IN_W-1:0] sq_n_r;
  logic [ROOT_W-1:0]  root;
  logic [ROOT_W-1:0]  root_r;
  logic [NUM_W-1:0]   dnum_r;
  logic [NUM_W-1:0]   cnum_r;
  logic [QUO_W-1:0]   dquo;
  logic [QUO_W-1:0]   cquo;
  res_t               res_r;
  res_t               res_nxt;
  res_t               skid_r;
  logic               skid_v_r;
  res_t               out_w;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tile_width_r  <= SIZE_RESET;
      tile_height_r <= SIZE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_TILE_WIDTH:  tile_width_r  <= cfg_wdata;
        REG_TILE_HEIGHT: tile_height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // The whole pipeline moves unless the skid register is occupied.
  assign en          = !skid_v_r;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NSTG-2:0], in_ch.valid};
    end
  end

  // Front stage: raw coordinates, step vectors and the rounded corner.
  always_comb begin
    logic [IDXC_W-1:0]          col_c, row_c;
    logic [IDXC_W+SIZE_W-1:0]   pc, pr;
    logic signed [COORD_W:0]    dfx, dfy, dsx, dsy;
    logic signed [COORD_W+2:0]  csx, csy;
    logic [COORD_W:0]           kfx, kfy, ksx, ksy, kcx, kcy;
    logic                       sat;

    col_c = (IDXC_W'(in_ch.tile_col) > IDXC_W'(MAX_TILE_INDEX)) ?
            IDXC_W'(MAX_TILE_INDEX) : IDXC_W'(in_ch.tile_col);
    row_c = (IDXC_W'(in_ch.tile_row) > IDXC_W'(MAX_TILE_INDEX)) ?
            IDXC_W'(MAX_TILE_INDEX) : IDXC_W'(in_ch.tile_row);
    pc = (IDXC_W+SIZE_W)'(col_c) * (IDXC_W+SIZE_W)'(tile_width_r);
    pr = (IDXC_W+SIZE_W)'(row_c) * (IDXC_W+SIZE_W)'(tile_height_r);

    dfx = (COORD_W+1)'(in_ch.next_fast_x) - (COORD_W+1)'(in_ch.first_x);
    dfy = (COORD_W+1)'(in_ch.next_fast_y) - (COORD_W+1)'(in_ch.first_y);
    dsx = (COORD_W+1)'(in_ch.next_slow_x) - (COORD_W+1)'(in_ch.first_x);
    dsy = (COORD_W+1)'(in_ch.next_slow_y) - (COORD_W+1)'(in_ch.first_y);

    // Corner is floor((2*first - fast - slow + 1) / 2) on the exact steps.
    csx = ((COORD_W+3)'(in_ch.first_x) <<< 1) - (COORD_W+3)'(dfx) - (COORD_W+3)'(dsx)
          + (COORD_W+3)'(1);
    csy = ((COORD_W+3)'(in_ch.first_y) <<< 1) - (COORD_W+3)'(dfy) - (COORD_W+3)'(dsy)
          + (COORD_W+3)'(1);

    kfx = clip_coord(WIDE_W'(dfx));
    kfy = clip_coord(WIDE_W'(dfy));
    ksx = clip_coord(WIDE_W'(dsx));
    ksy = clip_coord(WIDE_W'(dsy));
    kcx = clip_coord(WIDE_W'(csx >>> 1));
    kcy = clip_coord(WIDE_W'(csy >>> 1));

    sat = (pc > (IDXC_W+SIZE_W)'(RAW_MAX)) || (pr > (IDXC_W+SIZE_W)'(RAW_MAX)) ||
          kfx[COORD_W] || kfy[COORD_W] || ksx[COORD_W] || ksy[COORD_W] ||
          kcx[COORD_W] || kcy[COORD_W];

    side0.raw_col = (pc > (IDXC_W+SIZE_W)'(RAW_MAX)) ? RAW_MAX : pc[RAW_W-1:0];
    side0.raw_row = (pr > (IDXC_W+SIZE_W)'(RAW_MAX)) ? RAW_MAX : pr[RAW_W-1:0];
    side0.fx      = kfx[COORD_W-1:0];
    side0.fy      = kfy[COORD_W-1:0];
    side0.sx      = ksx[COORD_W-1:0];
    side0.sy      = ksy[COORD_W-1:0];
    side0.cx      = kcx[COORD_W-1:0];
    side0.cy      = kcy[COORD_W-1:0];
    side0.dot_mag = '0;
    side0.crs_mag = '0;
    side0.dot_neg = 1'b0;
    side0.degen   = ((kfx[COORD_W-1:0] == '0) && (kfy[COORD_W-1:0] == '0)) ||
                    ((kcx[COORD_W-1:0] == '0) && (kcy[COORD_W-1:0] == '0));
    side0.sat     = sat;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side0;
    end
  end

  // Second stage: the six products of the step and corner components.
  always_ff @(posedge clk) begin
    if (en) begin
      side_r[1] <= side_r[0];
      fxx_r     <= side_r[0].fx * side_r[0].fx;
      fyy_r     <= side_r[0].fy * side_r[0].fy;
      fxcx_r    <= side_r[0].fx * side_r[0].cx;
      fycy_r    <= side_r[0].fy * side_r[0].cy;
      fxcy_r    <= side_r[0].fx * side_r[0].cy;
      fycx_r    <= side_r[0].fy * side_r[0].cx;
    end
  end

  // Third stage: squared length, dot product and cross product magnitudes.
  always_ff @(posedge clk) begin
    logic [PROD_W-1:0]        nsq;
    logic signed [PROD_W:0]   dot, crs;
    side_t                    s;
    if (en) begin
      nsq = PROD_W'(fxx_r) + PROD_W'(fyy_r);
      dot = (PROD_W+1)'(fxcx_r) + (PROD_W+1)'(fycy_r);
      crs = (PROD_W+1)'(fxcy_r) - (PROD_W+1)'(fycx_r);
      s = side_r[1];
      s.dot_neg = dot[PROD_W];
      s.dot_mag = dot[PROD_W] ? MAG_W'(-dot) : MAG_W'(dot);
      s.crs_mag = crs[PROD_W] ? MAG_W'(-crs) : MAG_W'(crs);
      side_r[2] <= s;
      sq_n_r    <= {nsq, 16'h0000};
    end
  end

  // Square root: the fast-scan step length with eight extra fraction bits.
  atg_isqrt u_isqrt (
    .clk    (clk),
    .en     (en),
    .n_i    (sq_n_r),
    .root_o (root)
  );

  for (genvar k = SQ_FIRST; k <= DIV_LAST; k++) begin : g_side
    always_ff @(posedge clk) begin
      if (en) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  // Dividends with half the divisor added, for rounding to nearest.
  always_ff @(posedge clk) begin
    if (en) begin
      root_r <= root;
      dnum_r <= {side_r[SQ_LAST].dot_mag, 8'h00} + NUM_W'(root >> 1);
      cnum_r <= {side_r[SQ_LAST].crs_mag, 8'h00} + NUM_W'(root >> 1);
    end
  end

  atg_div u_div_dot (
    .clk   (clk),
    .en    (en),
    .num_i (dnum_r),
    .den_i (root_r),
    .quo_o (dquo)
  );

  atg_div u_div_crs (
    .clk   (clk),
    .en    (en),
    .num_i (cnum_r),
    .den_i (root_r),
    .quo_o (cquo)
  );

  // Last stage: virtual zero from the raw corner and the two quotients.
  always_comb begin
    logic signed [WIDE_W-1:0] bx, by, vx, vy;
    logic [COORD_W:0]         kvx, kvy;
    side_t                    s;
    s  = side_r[DIV_LAST];
    bx = signed'(WIDE_W'(s.raw_col) << FRAC_BITS);
    by = signed'(WIDE_W'(s.raw_row) << FRAC_BITS);
    if (s.degen) begin
      vx = bx;
      vy = by;
    end else begin
      vx = s.dot_neg ? (bx + signed'(WIDE_W'(dquo))) : (bx - signed'(WIDE_W'(dquo)));
      vy = by + signed'(WIDE_W'(cquo));
    end
    kvx = clip_coord(vx);
    kvy = clip_coord(vy);
    res_nxt.raw_col = s.raw_col;
    res_nxt.raw_row = s.raw_row;
    res_nxt.fx      = s.fx;
    res_nxt.fy      = s.fy;
    res_nxt.sx      = s.sx;
    res_nxt.sy      = s.sy;
    res_nxt.cx      = s.cx;
    res_nxt.cy      = s.cy;
    res_nxt.vx      = kvx[COORD_W-1:0];
    res_nxt.vy      = kvy[COORD_W-1:0];
    res_nxt.degen   = s.degen;
    res_nxt.sat     = s.sat || kvx[COORD_W] || kvy[COORD_W];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  // Skid register catches the result word when the sink stalls.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (out_ch.ready) begin
        skid_v_r <= 1'b0;
      end
    end else if (vld_r[FIN] && !out_ch.ready) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_v_r) begin
      skid_r <= res_r;
    end
  end

  assign out_w                 = skid_v_r ? skid_r : res_r;
  assign out_ch.valid          = skid_v_r || vld_r[FIN];
  assign out_ch.raw_first_col  = out_w.raw_col;
  assign out_ch.raw_first_row  = out_w.raw_row;
  assign out_ch.fast_step_x    = out_w.fx;
  assign out_ch.fast_step_y    = out_w.fy;
  assign out_ch.slow_step_x    = out_w.sx;
  assign out_ch.slow_step_y    = out_w.sy;
  assign out_ch.corner_x       = out_w.cx;
  assign out_ch.corner_y       = out_w.cy;
  assign out_ch.virtual_zero_x = out_w.vx;
  assign out_ch.virtual_zero_y = out_w.vy;
  assign out_ch.degenerate     = out_w.degen;
  assign out_ch.saturated      = out_w.sat;

  // An accepted word enters the first stage.
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> vld_r[0])
    else $error("accepted word did not enter the pipeline");

  // A degenerate tile has a zero fast step or a zero corner.
  a_degen_cause: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.degenerate) |->
    ((out_ch.fast_step_x == '0 && out_ch.fast_step_y == '0) ||
     (out_ch.corner_x == '0 && out_ch.corner_y == '0)))
    else $error("degenerate flag without a zero vector");

  // Without clipping, a degenerate tile's virtual zero is the raw corner.
  a_degen_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.degenerate && !out_ch.saturated) |->
    (out_ch.virtual_zero_x == COORD_W'(WIDE_W'(out_ch.raw_first_col) << FRAC_BITS) &&
     out_ch.virtual_zero_y == COORD_W'(WIDE_W'(out_ch.raw_first_row) << FRAC_BITS)))
    else $error("degenerate virtual zero differs from the raw corner");

endmodule

`default_nettype wire
